// ===== src/gst_pkg.sv =====
// Package: shared types, codes and constants of the generational slot table.
package gst_pkg;

    // Default region sizes
    localparam int DEF_LOCAL_SLOTS = 64;
    localparam int DEF_NET_SLOTS   = 64;

    // Field widths fixed by the item format
    localparam int KEY_W   = 7;
    localparam int TICK_W  = 32;
    localparam int FLAGS_W = 32;
    localparam int STAT_W  = 2;
    localparam int CAT_W   = 2;

    // Width of one used-bit group searched in a single step
    localparam int GROUP_W = 32;
    localparam int GBIT_W  = $clog2(GROUP_W);

    // Item operations
    localparam logic MODE_CREATE = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // Region selections for create
    localparam logic [CAT_W-1:0] CAT_LOCAL = 2'd1;
    localparam logic [CAT_W-1:0] CAT_NET   = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADCAT = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_PICK,
        S_CLAIM,
        S_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic dec;
        logic pick;
        logic claim;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_lookup;
        logic cat_bad;
        logic out_free;
    } t_sts;

endpackage

// ===== src/gst_ctrl.sv =====
// Controller: sequences accept, decode, group pick, claim and emit of one item.
module gst_ctrl
    import gst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output logic o_stall,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through the steps of one item
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_lookup || i_sts.cat_bad) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_PICK:  n_state = S_CLAIM;
            S_CLAIM: n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Drive commands for the current step
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            S_DEC:   o_cmd.dec   = 1'b1;
            S_PICK:  o_cmd.pick  = 1'b1;
            S_CLAIM: o_cmd.claim = 1'b1;
            S_EMIT:  o_cmd.emit  = i_sts.out_free;
            default: o_stall     = 1'b1;
        endcase
    end

endmodule

// ===== src/gst_dpath.sv =====
// Datapath: used bits, tick and flag memory, free-slot search and result registers.
module gst_dpath
    import gst_pkg::*;
#(
    parameter int LOCAL_SLOTS = DEF_LOCAL_SLOTS,
    parameter int NET_SLOTS   = DEF_NET_SLOTS
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_mode,
    input  logic [CAT_W-1:0]   i_category_bits,
    input  logic [KEY_W-1:0]   i_key_index,
    input  logic [TICK_W-1:0]  i_key_tick,
    input  logic [TICK_W-1:0]  i_tick_now,
    input  logic [FLAGS_W-1:0] i_new_flags,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [KEY_W-1:0]   o_slot_index,
    output logic [TICK_W-1:0]  o_slot_tick,
    output logic [FLAGS_W-1:0] o_slot_flags
);

    localparam int TOTAL = LOCAL_SLOTS + NET_SLOTS;
    localparam int AW    = $clog2(TOTAL);
    localparam int NG    = (TOTAL + GROUP_W - 1) / GROUP_W;
    localparam int PADW  = NG * GROUP_W;
    localparam int PIW   = $clog2(PADW);
    localparam int GIW   = (NG > 1) ? $clog2(NG) : 1;

    // Latched item
    logic               r_mode;
    logic [CAT_W-1:0]   r_cat;
    logic [KEY_W-1:0]   r_kidx;
    logic [TICK_W-1:0]  r_ktick;
    logic [TICK_W-1:0]  r_now;
    logic [FLAGS_W-1:0] r_flags;

    // Slot state
    logic [PADW-1:0]               r_used;
    logic [TICK_W+FLAGS_W-1:0]     r_mem [TOTAL];
    logic [TICK_W+FLAGS_W-1:0]     r_rd;

    // Search state
    logic [NG-1:0]  r_gfree;
    logic [GIW-1:0] r_grp;
    logic           r_any;

    // Pending result
    logic [STAT_W-1:0]  r_res_status;
    logic [KEY_W-1:0]   r_res_index;
    logic [TICK_W-1:0]  r_res_tick;
    logic [FLAGS_W-1:0] r_res_flags;

    logic               r_out_valid;

    logic [31:0]        key32;
    logic [31:0]        lkey32;
    logic [AW-1:0]      rd_addr;
    logic [PADW-1:0]    free_bits;
    logic [NG-1:0]      n_gfree;
    logic [GIW-1:0]     n_grp;
    logic [GROUP_W-1:0] grp_word;
    logic [GBIT_W-1:0]  bit_sel;
    logic [31:0]        slot32;
    logic [AW-1:0]      slot_addr;
    logic [PIW-1:0]     slot_pidx;
    logic               we;
    logic               allowed;
    logic               hit;
    logic [TICK_W-1:0]  rd_tick;
    logic [FLAGS_W-1:0] rd_flags;

    assign key32     = 32'(i_key_index);
    assign lkey32    = 32'(r_kidx);
    assign rd_addr   = key32[AW-1:0];
    assign rd_tick   = r_rd[TICK_W+FLAGS_W-1:FLAGS_W];
    assign rd_flags  = r_rd[FLAGS_W-1:0];

    // Latch the item on acceptance
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode  <= i_mode;
            r_cat   <= i_category_bits;
            r_kidx  <= i_key_index;
            r_ktick <= i_key_tick;
            r_now   <= i_tick_now;
            r_flags <= i_new_flags;
        end
    end

    // Mark free slots inside the requested region
    always_comb begin
        for (int j = 0; j < PADW; j++) begin
            free_bits[j] = !r_used[j] &&
                ((r_cat == CAT_LOCAL && j < LOCAL_SLOTS) ||
                 (r_cat == CAT_NET && j >= LOCAL_SLOTS && j < TOTAL));
        end
        for (int g = 0; g < NG; g++) begin
            n_gfree[g] = |free_bits[g*GROUP_W +: GROUP_W];
        end
    end

    // Find the lowest group with a free slot
    always_comb begin
        n_grp = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_gfree[g]) begin
                n_grp = GIW'(g);
            end
        end
    end

    // Find the lowest free slot within the chosen group
    always_comb begin
        grp_word = free_bits[r_grp*GROUP_W +: GROUP_W];
        bit_sel  = '0;
        for (int b = GROUP_W - 1; b >= 0; b--) begin
            if (grp_word[b]) begin
                bit_sel = GBIT_W'(b);
            end
        end
    end

    assign slot32    = 32'(r_grp) * 32'(GROUP_W) + 32'(bit_sel);
    assign slot_addr = slot32[AW-1:0];
    assign slot_pidx = slot32[PIW-1:0];
    assign we        = i_cmd.claim && r_any;

    // Check the lookup key against region, used bit and stored tick
    assign allowed = (r_cat[0] && lkey32 < 32'(LOCAL_SLOTS)) ||
                     (r_cat[1] && lkey32 >= 32'(LOCAL_SLOTS) && lkey32 < 32'(TOTAL));
    assign hit     = allowed && r_used[lkey32[PIW-1:0]] && (rd_tick == r_ktick);

    // Tick and flag memory: write on claim, registered read on acceptance
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[slot_addr] <= {r_now, r_flags};
        end
        if (i_cmd.accept) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Set used bits on claim
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (we) begin
            r_used[slot_pidx] <= 1'b1;
        end
    end

    // Hold search progress
    always_ff @(posedge i_clk) begin
        if (i_cmd.dec) begin
            r_gfree <= n_gfree;
        end
        if (i_cmd.pick) begin
            r_grp <= n_grp;
            r_any <= |r_gfree;
        end
    end

    // Form the pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.dec) begin
            if (r_mode == MODE_LOOKUP) begin
                if (hit) begin
                    r_res_status <= ST_OK;
                    r_res_index  <= r_kidx;
                    r_res_tick   <= rd_tick;
                    r_res_flags  <= rd_flags;
                end else begin
                    r_res_status <= ST_MISS;
                    r_res_index  <= '0;
                    r_res_tick   <= '0;
                    r_res_flags  <= '0;
                end
            end else begin
                r_res_status <= ST_BADCAT;
                r_res_index  <= '0;
                r_res_tick   <= '0;
                r_res_flags  <= '0;
            end
        end else if (i_cmd.claim) begin
            if (r_any) begin
                r_res_status <= ST_OK;
                r_res_index  <= slot32[KEY_W-1:0];
                r_res_tick   <= r_now;
                r_res_flags  <= r_flags;
            end else begin
                r_res_status <= ST_MISS;
                r_res_index  <= '0;
                r_res_tick   <= '0;
                r_res_flags  <= '0;
            end
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status     <= r_res_status;
            o_slot_index <= r_res_index;
            o_slot_tick  <= r_res_tick;
            o_slot_flags <= r_res_flags;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sts.is_lookup = (r_mode == MODE_LOOKUP);
    assign o_sts.cat_bad   = (r_cat != CAT_LOCAL) && (r_cat != CAT_NET);
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    // A claimed slot was free before and is used afterwards
    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> !r_used[slot_pidx])
        else $error("claimed slot already used");

    a_claim_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> r_used[$past(slot_pidx)])
        else $error("claimed slot not marked used");

    // Only a valid region reaches the search
    a_pick_cat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick |-> (r_cat == CAT_LOCAL || r_cat == CAT_NET))
        else $error("search started for a bad category");

    // A result never overwrites one still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_stall))
        else $error("result loaded over a waiting item");

endmodule

// ===== src/generational_slot_table.sv =====
// Top level: generational slot table with local and network regions.
// The table takes one item at a time. A lookup is loaded into the output
// register after memory read at acceptance and compare. A create is loaded
// after per-group free scan, group select and slot claim with memory write.
// A create with a bad category skips the search and is loaded after decode.
// The next item is accepted in the cycle after the result is loaded into the
// output register. A stalled output holds the item in the load step. These
// steps are set by the tick and flag memory with registered read, and by the
// two-step search of the used bits in groups of 32. The used bits are cleared
// at reset at once; the tick and flag memory is written only when a slot is
// claimed.
module generational_slot_table
    import gst_pkg::*;
#(
    parameter int LOCAL_SLOTS = DEF_LOCAL_SLOTS,
    parameter int NET_SLOTS   = DEF_NET_SLOTS
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [CAT_W-1:0]   i_category_bits,
    input  logic [KEY_W-1:0]   i_key_index,
    input  logic [TICK_W-1:0]  i_key_tick,
    input  logic [TICK_W-1:0]  i_tick_now,
    input  logic [FLAGS_W-1:0] i_new_flags,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [KEY_W-1:0]   o_slot_index,
    output logic [TICK_W-1:0]  o_slot_tick,
    output logic [FLAGS_W-1:0] o_slot_flags
);

    t_cmd cmd;
    t_sts sts;

    // Sequence each item
    gst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // Hold slot state and compute results
    gst_dpath #(
        .LOCAL_SLOTS (LOCAL_SLOTS),
        .NET_SLOTS   (NET_SLOTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_category_bits (i_category_bits),
        .i_key_index     (i_key_index),
        .i_key_tick      (i_key_tick),
        .i_tick_now      (i_tick_now),
        .i_new_flags     (i_new_flags),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_slot_tick     (o_slot_tick),
        .o_slot_flags    (o_slot_flags)
    );

endmodule
